/* hw/rtl/mcwds_pkg.sv */
// Shared constants, request codes and control/status types of the watchdog supervisor.
`timescale 1ns / 1ps

package mcwds_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    localparam int REQ_W     = 3;
    localparam int CHAN_W    = 3;
    localparam int PERIOD_W  = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REGISTER = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENTER    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_EXIT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_KICK     = 3'd5;

    typedef struct packed {
        logic latch_req;
        logic tick_start;
        logic rd_en;
        logic scan_end;
        logic exec;
        logic out_load_tick;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic hit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/mcwds_ctrl.sv */
// Sequencer: accepts request words, steps the channel scan and hands results to the output stage.
`timescale 1ns / 1ps

module mcwds_ctrl
    import mcwds_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  dp_status_t       status,
    output ctrl_cmd_t        cmd,
    output logic [IDX_W-1:0] rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             ready_reg, ready_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             issue;

    assign accept   = s_tvalid && ready_reg;
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(NUM_CHANNELS));
    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign s_tready = ready_reg;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.latch_req  = accept;
        cmd.tick_start = accept && status.in_tick;
        cmd.rd_en      = issue;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = status.in_tick ? ST_SCAN : ST_EXEC;
                    ready_next = 1'b0;
                    cnt_next   = '0;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // first expired channel ends the scan, as does the check of the last one
                if (status.hit || status.last) begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load_tick = 1'b1;
                    state_next        = ST_IDLE;
                    ready_next        = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hw/rtl/mcwds_dp.sv */
// Datapath: channel bits, period and stamp memories, ms clock, expiry compare, output register.
`timescale 1ns / 1ps

module mcwds_dp
    import mcwds_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF,
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int CMP_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  ctrl_cmd_t            cmd,
    input  logic [IDX_W-1:0]     rd_addr,
    output dp_status_t           status
);

    logic [PERIOD_W-1:0]  period_mem [NUM_CHANNELS];
    logic [TIME_BITS-1:0] start_mem  [NUM_CHANNELS];

    logic [REQ_W-1:0]     req_reg;
    logic [CHAN_W-1:0]    ch_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [NUM_CHANNELS-1:0] regd_reg, regd_next;
    logic [NUM_CHANNELS-1:0] armed_reg, armed_next;

    logic                 chk_vld_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    logic [PERIOD_W-1:0]  per_rd_reg;
    logic [TIME_BITS-1:0] stamp_rd_reg;

    logic              exp_reg;
    logic [CHAN_W-1:0] exp_ch_reg;

    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [7:0]              ch_wide;
    logic                    ch_ok;
    logic [IDX_W-1:0]        ch_idx;
    logic [NUM_CHANNELS-1:0] ch_sel;
    logic [TIME_BITS-1:0]    elapsed;
    logic [CMP_W-1:0]        elapsed_ext;
    logic [CMP_W-1:0]        period_ext;
    logic                    hit;
    logic [7:0]              chk_wide;
    logic                    start_pulse;
    logic                    stop_pulse;
    logic                    stamp_wr;
    logic                    out_free;

    assign ch_wide = {5'b0, ch_reg};
    assign ch_ok   = ch_wide < 8'(NUM_CHANNELS);
    assign ch_idx  = ch_wide[IDX_W-1:0];
    assign ch_sel  = NUM_CHANNELS'(1) << ch_idx;

    // elapsed time wraps with the ms clock
    assign elapsed     = now_reg - stamp_rd_reg;
    assign elapsed_ext = CMP_W'(elapsed);
    assign period_ext  = CMP_W'(per_rd_reg);
    assign hit = chk_vld_reg && regd_reg[chk_idx_reg] && armed_reg[chk_idx_reg]
                 && (elapsed_ext >= period_ext);
    assign chk_wide = 8'(chk_idx_reg);

    assign start_pulse = (req_reg == REQ_REGISTER) && ch_ok && (regd_reg == '0);
    assign stop_pulse  = (req_reg == REQ_RELEASE) && ch_ok && regd_reg[ch_idx]
                         && ((regd_reg & ~ch_sel) == '0);
    assign stamp_wr = ch_ok && regd_reg[ch_idx]
                      && (((req_reg == REQ_ENTER) && !armed_reg[ch_idx])
                          || (req_reg == REQ_KICK));

    assign out_free = !out_vld_reg || m_tready;

    assign status.in_tick  = (s_tuser == REQ_TICK);
    assign status.hit      = hit;
    assign status.last     = chk_vld_reg && (chk_idx_reg == IDX_W'(NUM_CHANNELS - 1));
    assign status.out_free = out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        regd_next  = regd_reg;
        armed_next = armed_reg;
        if (cmd.exec && ch_ok) begin
            case (req_reg)
                REQ_REGISTER: begin
                    regd_next[ch_idx]  = 1'b1;
                    armed_next[ch_idx] = 1'b0;
                end
                REQ_RELEASE: begin
                    regd_next[ch_idx]  = 1'b0;
                    armed_next[ch_idx] = 1'b0;
                end
                REQ_ENTER, REQ_KICK: begin
                    if (regd_reg[ch_idx]) begin
                        armed_next[ch_idx] = 1'b1;
                    end
                end
                REQ_EXIT: begin
                    armed_next[ch_idx] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg    <= s_tuser;
            ch_reg     <= s_tdata[CHAN_W-1:0];
            period_reg <= s_tdata[CHAN_W +: PERIOD_W];
        end
        if (cmd.exec && ch_ok && (req_reg == REQ_REGISTER)) begin
            period_mem[ch_idx] <= period_reg;
        end
        if (cmd.exec && stamp_wr) begin
            start_mem[ch_idx] <= now_reg;
        end
        if (cmd.rd_en) begin
            per_rd_reg   <= period_mem[rd_addr];
            stamp_rd_reg <= start_mem[rd_addr];
            chk_idx_reg  <= rd_addr;
        end
        if (cmd.scan_end) begin
            exp_reg    <= hit;
            exp_ch_reg <= hit ? chk_wide[CHAN_W-1:0] : '0;
        end
        if (cmd.exec) begin
            out_data_reg <= {5'b0, stop_pulse, start_pulse, 1'b0};
        end else if (cmd.out_load_tick) begin
            out_data_reg <= {1'b0, exp_ch_reg, exp_reg, 2'b0, !exp_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg     <= '0;
            regd_reg    <= '0;
            armed_reg   <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.tick_start) begin
                now_reg <= now_reg + TIME_BITS'(1);
            end
            regd_reg    <= regd_next;
            armed_reg   <= armed_next;
            chk_vld_reg <= cmd.rd_en;
            if (cmd.exec || cmd.out_load_tick) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/multi_channel_watchdog_supervisor_top.sv */
// Top level of the multi-channel watchdog supervisor.
`timescale 1ns / 1ps

// Supervises NUM_CHANNELS software watchdog channels against an ms clock (TIME_BITS
// wide, wrapping) advanced by each tick word, and decides per tick word whether the
// hardware watchdog is fed. Each input word gives exactly one result word. Register,
// release, enter, exit and kick go through the exec state, which waits for a free output
// register; a tick runs the channel scan, which reads the period and stamp memories one
// entry a cycle and stops at the lowest expired channel. One word is worked on at a time;
// the next is accepted as soon as the previous result sits in the output register.
// Channels at or above NUM_CHANNELS, and request codes 6 and 7, change nothing.

module multi_channel_watchdog_supervisor_top
    import mcwds_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF,
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // channel[2:0], period_value[34:3], zero fill
    input  logic [REQ_W-1:0]     s_tuser,   // req_type[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // hw_kick[0], hw_start[1], hw_stop[2],
                                            // expired_flag[3], expired_channel[6:4], zero[7]
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] rd_addr;

    mcwds_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    mcwds_dp #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .status  (status)
    );

endmodule
